@@ hw/rtl/ffa_pkg.sv @@
// shared constants, types and helpers for the first-fit arena allocator
`timescale 1ns / 1ps
package ffa_pkg;
  localparam int ARENA_BYTES  = 1024;
  localparam int HEADER_BYTES = 32;
  localparam int SLOTS        = ARENA_BYTES / 4;
  localparam int SLW          = $clog2(SLOTS);
  localparam int SW           = $clog2(ARENA_BYTES);
  localparam int AW           = $clog2(ARENA_BYTES) + 1;
  localparam int FW           = 10;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ZERO  = 2'd1;
  localparam logic [1:0] ST_NOFIT = 2'd2;
  localparam logic [1:0] ST_BAD   = 2'd3;

  localparam logic [AW-1:0] HDR   = AW'(HEADER_BYTES);
  localparam logic [AW-1:0] ARENA = AW'(ARENA_BYTES);

  typedef struct packed {
    logic          used;
    logic [SW-1:0] size;
  } ent_t;

  // header slot of a block start byte
  function automatic logic [SLW-1:0] slot_of(input logic [AW-1:0] a);
    return a[SLW+1:2];
  endfunction
endpackage

@@ hw/rtl/first_fit_arena_allocator_core.sv @@
// first-fit arena allocator with coalescing, header store walker
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid/in_ready) carries one request: op 0 allocates
//   req_bytes, op 1 frees the block whose data offset is free_offset.
//   Output channel (out_valid/out_ready) returns one result per request:
//   status and data_offset (zero unless an allocate succeeds).
//   Block headers live in one single-port-write synchronous memory, one
//   entry per 4-byte slot, read through a registered read port.
//   Steps from the accepting edge to out_valid: an allocate reads and then
//   evaluates each block header walked, writes the split-off free header and
//   its own header when the block is split, and loads the output register. A
//   free walks the headers to the target, reads and writes for the merges,
//   and loads the output register. A zero-size allocate goes straight to it.
//   The header walk (one memory read per block) dominates; a fully
//   fragmented arena holds at most 28 blocks.
//   One request is in work at a time; in_ready is high only while idle, so
//   the next request is taken the cycle after a result is loaded.
//   A finished result waits in the output register; a new request may be
//   taken meanwhile, and its result holds until the register is free.
//   Reset: the arena becomes one free block (header entry 0 written during
//   reset), output empty, ready for a request the cycle after reset.
module first_fit_arena_allocator_core
  import ffa_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          op,
  input  logic [9:0]    req_bytes,
  input  logic [9:0]    free_offset,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    status,
  output logic [FW-1:0] data_offset
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;
  localparam logic [3:0] S_EV    = 4'd2;
  localparam logic [3:0] S_SPL   = 4'd3;
  localparam logic [3:0] S_FN_RD = 4'd4;
  localparam logic [3:0] S_FN_EV = 4'd5;
  localparam logic [3:0] S_FP_RD = 4'd6;
  localparam logic [3:0] S_FP_EV = 4'd7;
  localparam logic [3:0] S_PUT   = 4'd8;

  logic [3:0]    state, state_next;
  logic          opr, opr_next;
  logic [AW-1:0] need, need_next;
  logic [AW-1:0] offs, offs_next;
  logic [AW-1:0] start, start_next;
  logic [AW-1:0] prev, prev_next;
  logic [AW-1:0] nbr, nbr_next;
  logic          have_prev, have_prev_next;
  logic [SW-1:0] cur, cur_next;
  logic [1:0]    res_st, res_st_next;
  logic [FW-1:0] res_off, res_off_next;

  // header memory
  ent_t          mem [SLOTS];
  ent_t          rdata, wdata;
  logic          we;
  logic [SLW-1:0] waddr, raddr;

  always_ff @(posedge clk) begin
    if (rst) begin
      mem[0] <= '{used: 1'b0, size: SW'(ARENA_BYTES - HEADER_BYTES)};
    end else if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  logic [AW-1:0] nxt, split_at;
  assign nxt      = start + HDR + AW'(rdata.size);
  assign split_at = start + HDR + need;
  assign in_ready = (state == S_IDLE) && !rst;

  // walk and update sequencer
  always_comb begin
    state_next     = state;
    opr_next       = opr;
    need_next      = need;
    offs_next      = offs;
    start_next     = start;
    prev_next      = prev;
    nbr_next       = nbr;
    have_prev_next = have_prev;
    cur_next       = cur;
    res_st_next    = res_st;
    res_off_next   = res_off;
    we             = 1'b0;
    waddr          = slot_of(start);
    wdata          = rdata;
    raddr          = slot_of(start);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          opr_next       = op;
          need_next      = (AW'(req_bytes) + AW'(3)) & ~AW'(3);
          offs_next      = AW'(free_offset);
          start_next     = '0;
          have_prev_next = 1'b0;
          res_off_next   = '0;
          if (!op && req_bytes == '0) begin
            res_st_next = ST_ZERO;
            state_next  = S_PUT;
          end else begin
            state_next = S_RD;
          end
        end
      end
      S_RD: begin
        state_next = S_EV;
      end
      S_EV: begin
        if (!opr) begin
          if (!rdata.used && AW'(rdata.size) >= need) begin
            we           = 1'b1;
            res_st_next  = ST_OK;
            res_off_next = FW'(start + HDR);
            if (AW'(rdata.size) >= need + HDR + AW'(4)) begin
              waddr      = slot_of(split_at);
              wdata      = '{used: 1'b0, size: SW'(AW'(rdata.size) - HDR - need)};
              state_next = S_SPL;
            end else begin
              wdata      = '{used: 1'b1, size: rdata.size};
              state_next = S_PUT;
            end
          end else if (nxt >= ARENA) begin
            res_st_next = ST_NOFIT;
            state_next  = S_PUT;
          end else begin
            start_next = nxt;
            state_next = S_RD;
          end
        end else begin
          if (start + HDR == offs) begin
            cur_next    = rdata.size;
            nbr_next    = nxt;
            res_st_next = ST_OK;
            if (nxt < ARENA) begin
              state_next = S_FN_RD;
            end else begin
              we         = 1'b1;
              wdata      = '{used: 1'b0, size: rdata.size};
              state_next = have_prev ? S_FP_RD : S_PUT;
            end
          end else if (nxt >= ARENA) begin
            res_st_next = ST_BAD;
            state_next  = S_PUT;
          end else begin
            prev_next      = start;
            have_prev_next = 1'b1;
            start_next     = nxt;
            state_next     = S_RD;
          end
        end
      end
      S_SPL: begin
        we         = 1'b1;
        wdata      = '{used: 1'b1, size: need[SW-1:0]};
        state_next = S_PUT;
      end
      S_FN_RD: begin
        raddr      = slot_of(nbr);
        state_next = S_FN_EV;
      end
      S_FN_EV: begin
        // forward merge with a free successor
        if (!rdata.used) begin
          cur_next = SW'(AW'(cur) + HDR + AW'(rdata.size));
        end
        we         = 1'b1;
        wdata      = '{used: 1'b0, size: cur_next};
        state_next = have_prev ? S_FP_RD : S_PUT;
      end
      S_FP_RD: begin
        raddr      = slot_of(prev);
        state_next = S_FP_EV;
      end
      S_FP_EV: begin
        // backward merge into a free predecessor
        waddr = slot_of(prev);
        wdata = '{used: 1'b0, size: SW'(AW'(rdata.size) + HDR + AW'(cur))};
        we    = !rdata.used;
        state_next = S_PUT;
      end
      S_PUT: begin
        if (!out_valid || out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control and output registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_PUT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (state == S_PUT && (!out_valid || out_ready)) begin
      status      <= res_st;
      data_offset <= (res_st == ST_OK) ? res_off : '0;
    end
    opr       <= opr_next;
    need      <= need_next;
    offs      <= offs_next;
    start     <= start_next;
    prev      <= prev_next;
    nbr       <= nbr_next;
    have_prev <= have_prev_next;
    cur       <= cur_next;
    res_st    <= res_st_next;
    res_off   <= res_off_next;
  end

  // checks
  a_off_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> data_offset == '0)
    else $error("nonzero offset on failed request");
  a_no_wr_rd: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD || state == S_FN_RD || state == S_FP_RD) |-> !we)
    else $error("write during read cycle");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted while busy");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !op && req_bytes == '0 |=> state == S_PUT && res_st == ST_ZERO)
    else $error("zero size not rejected");
endmodule

@@ verif/tb_first_fit_arena_allocator_core.sv @@
// testbench for the first-fit arena allocator core with a self-checking scoreboard
`timescale 1ns / 1ps
module tb_first_fit_arena_allocator_core;
  import ffa_pkg::*;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;
  localparam int   N_RANDOM = 1780;
  localparam int   STALL_LIMIT = 4000;

  typedef struct {
    logic [1:0] st;
    logic [9:0] offs;
  } alloc_result_t;

  // arena model and queue of pending answers
  class arena_scoreboard;
    int unsigned   blk_size[SLOTS];
    bit            blk_used[SLOTS];
    alloc_result_t pending[$];
    int            errors;

    function void clear_arena();
      foreach (blk_size[i]) begin
        blk_size[i] = 0;
        blk_used[i] = 0;
      end
      blk_size[0] = ARENA_BYTES - HEADER_BYTES;
      pending.delete();
      errors = 0;
    endfunction

    function int unsigned slot(int unsigned start);
      return (start >> 2) % SLOTS;
    endfunction

    function alloc_result_t do_alloc(int unsigned req);
      alloc_result_t r;
      int unsigned need, start, s, sz, nb;
      r.st = ST_NOFIT;
      r.offs = '0;
      need = (req + 3) & ~32'd3;
      start = 0;
      if (need == 0) begin
        r.st = ST_ZERO;
        return r;
      end
      while (start < ARENA_BYTES) begin
        s = slot(start);
        sz = blk_size[s];
        if (!blk_used[s] && sz >= need) begin
          // split when the leftover holds a header and a minimal data area
          if (sz >= need + HEADER_BYTES + 4) begin
            nb = start + HEADER_BYTES + need;
            blk_size[slot(nb)] = sz - HEADER_BYTES - need;
            blk_used[slot(nb)] = 0;
            blk_size[s] = need;
          end
          blk_used[s] = 1;
          r.st = ST_OK;
          r.offs = 10'(start + HEADER_BYTES);
          return r;
        end
        start = start + HEADER_BYTES + sz;
      end
      return r;
    endfunction

    function alloc_result_t do_free(int unsigned offs);
      alloc_result_t r;
      int unsigned start, prev, s, nb;
      bit have_prev;
      r.st = ST_BAD;
      r.offs = '0;
      start = 0;
      prev = 0;
      have_prev = 0;
      while (start < ARENA_BYTES) begin
        s = slot(start);
        if (start + HEADER_BYTES == offs) begin
          nb = start + HEADER_BYTES + blk_size[s];
          blk_used[s] = 0;
          // merge forward, then backward
          if (nb < ARENA_BYTES && !blk_used[slot(nb)])
            blk_size[s] += HEADER_BYTES + blk_size[slot(nb)];
          if (have_prev && !blk_used[slot(prev)])
            blk_size[slot(prev)] += HEADER_BYTES + blk_size[s];
          r.st = ST_OK;
          return r;
        end
        prev = start;
        have_prev = 1;
        start = start + HEADER_BYTES + blk_size[s];
      end
      return r;
    endfunction

    function alloc_result_t note_request(logic o, logic [9:0] req, logic [9:0] offs);
      alloc_result_t r;
      if (o == OP_ALLOC) r = do_alloc(32'(req));
      else r = do_free(32'(offs));
      pending.push_back(r);
      return r;
    endfunction

    function void check_result(logic [1:0] st, logic [9:0] offs);
      alloc_result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result status=%0d data_offset=%0d", st, offs);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (st !== e.st) begin
        $error("status: expected %0d, actual %0d", e.st, st);
        errors++;
      end
      if (offs !== e.offs) begin
        $error("data_offset: expected %0d, actual %0d", e.offs, offs);
        errors++;
      end
    endfunction
  endclass

  logic       clk = 0;
  logic       rst = 1;
  logic       in_valid = 0;
  logic       in_ready;
  logic       op = OP_ALLOC;
  logic [9:0] req_bytes = '0;
  logic [9:0] free_offset = '0;
  logic       out_valid;
  logic       out_ready = 0;
  logic [1:0] status;
  logic [9:0] data_offset;

  arena_scoreboard sb;
  logic [9:0] live[$];
  logic [9:0] freed[$];
  bit   quiet = 0;
  bit   hold_off = 0;
  bit   stim_done = 0;
  int   idle_cycles = 0;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  first_fit_arena_allocator_core dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .op(op),
    .req_bytes(req_bytes), .free_offset(free_offset), .out_valid(out_valid),
    .out_ready(out_ready), .status(status), .data_offset(data_offset)
  );

  // drive one request and wait for it to be taken
  task automatic send(logic o, logic [9:0] req, logic [9:0] offs);
    alloc_result_t r;
    int gap;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      gap = $urandom_range(1, 10);
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1;
    op <= o;
    req_bytes <= req;
    free_offset <= offs;
    do @(posedge clk); while (!in_ready);
    r = sb.note_request(o, req, offs);
    if (o == OP_ALLOC && r.st == ST_OK) live.push_back(r.offs);
  endtask

  task automatic release_live(int idx);
    logic [9:0] a;
    a = live[idx];
    live.delete(idx);
    freed.push_back(a);
    if (freed.size() > 16) void'(freed.pop_front());
    send(OP_FREE, 10'($urandom_range(0, 1023)), a);
  endtask

  // receiver with random stall bursts and one long hold-off
  initial begin
    int n;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off) begin
        out_ready <= 0;
        repeat (300) @(negedge clk);
        hold_off = 0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 0;
        n = $urandom_range(1, 10);
        repeat (n) @(negedge clk);
      end else begin
        out_ready <= 1;
        n = $urandom_range(1, 12);
        repeat (n) @(negedge clk);
      end
    end
  end

  // result check and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_result(status, data_offset);
      if ((out_valid && out_ready) || (in_valid && in_ready)) idle_cycles <= 0;
      else if (!stim_done || sb.pending.size() != 0) idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    int k, pick;
    sb = new();
    sb.clear_arena();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: zero size, oversize, whole-arena fit and free, bad addresses
    send(OP_ALLOC, 10'd0, 10'h3FF);
    send(OP_ALLOC, 10'd1023, 10'd0);
    send(OP_ALLOC, 10'd992, 10'd0);
    send(OP_ALLOC, 10'd1, 10'd0);
    send(OP_FREE, 10'h3FF, 10'd32);
    send(OP_FREE, 10'd0, 10'd32);
    send(OP_FREE, 10'd0, 10'd0);
    send(OP_FREE, 10'd0, 10'd33);
    send(OP_FREE, 10'd0, 10'h3FF);
    // directed: split, merge forward, merge backward, double free
    live.delete();
    send(OP_ALLOC, 10'd5, 10'd0);
    send(OP_ALLOC, 10'd60, 10'd0);
    send(OP_ALLOC, 10'd3, 10'd0);
    send(OP_ALLOC, 10'd100, 10'd0);
    send(OP_FREE, 10'd0, live[0]);
    send(OP_FREE, 10'd0, live[2]);
    send(OP_FREE, 10'd0, live[1]);
    send(OP_FREE, 10'd0, live[1]);
    send(OP_FREE, 10'd0, live[3]);
    send(OP_ALLOC, 10'd900, 10'd0);
    live.delete();
    live.push_back(10'd32);
    release_live(0);

    // random: mostly valid alloc/free traffic, some noise
    for (k = 0; k < N_RANDOM; k++) begin
      if (k == 600) hold_off = 1;
      if (k == N_RANDOM - 250) quiet = 1;
      pick = $urandom_range(0, 99);
      if (pick < 45 || live.size() == 0) begin
        if ($urandom_range(0, 9) == 0)
          send(OP_ALLOC, 10'($urandom_range(0, 1023)), 10'($urandom));
        else
          send(OP_ALLOC, 10'($urandom_range(1, 96)), 10'($urandom_range(0, 1023)));
      end else if (pick < 88) begin
        release_live($urandom_range(0, live.size() - 1));
      end else if (pick < 94 && freed.size() != 0) begin
        send(OP_FREE, 10'($urandom_range(0, 1023)),
             freed[$urandom_range(0, freed.size() - 1)]);
      end else begin
        send(OP_FREE, 10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
      end
    end
    @(negedge clk);
    in_valid <= 0;
    stim_done = 1;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule
